[src/simd_lane_reorder_unit_defines.svh]
// ----------------------------------------------------------------------------
// SIMD lane reorder unit: assertion macros
// Shared helpers for the concurrent checks on the reorder unit.
// ----------------------------------------------------------------------------
`ifndef SIMD_LANE_REORDER_UNIT_DEFINES_SVH
`define SIMD_LANE_REORDER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, muted while reset is low
`define SLRU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, muted while reset is low
`define SLRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/slru_pkg.sv]
// ----------------------------------------------------------------------------
// SIMD lane reorder unit package
// Widths and action codes shared by the reorder unit and its checker.
// ----------------------------------------------------------------------------
package slru_pkg;

  localparam int ActionW = 5;
  localparam int HalfW   = 64;
  localparam int VecW    = 2 * HalfW;

  // number of defined action codes; codes at or above this give zero
  localparam int ActionCount = 20;

  typedef enum logic [ActionW-1:0] {
    ACT_COPY_HW       = 5'd0,
    ACT_COPY_LO_DW    = 5'd1,
    ACT_COPY_UP_DW    = 5'd2,
    ACT_EXCH_CTR_HW   = 5'd3,
    ACT_EXCH_CTR_W    = 5'd4,
    ACT_EXCH_EVEN_HW  = 5'd5,
    ACT_EXCH_EVEN_W   = 5'd6,
    ACT_EXT_LO_B      = 5'd7,
    ACT_EXT_LO_HW     = 5'd8,
    ACT_EXT_LO_W      = 5'd9,
    ACT_EXT_UP_B      = 5'd10,
    ACT_EXT_UP_HW     = 5'd11,
    ACT_EXT_UP_W      = 5'd12,
    ACT_INTLV_EVEN_HW = 5'd13,
    ACT_INTLV_HW      = 5'd14,
    ACT_PACK_B        = 5'd15,
    ACT_PACK_HW       = 5'd16,
    ACT_PACK_W        = 5'd17,
    ACT_REV_HW        = 5'd18,
    ACT_ROT3_W        = 5'd19
  } action_t;

  typedef logic [VecW-1:0] vec_t;

endpackage

[src/slru_permute.sv]
// ----------------------------------------------------------------------------
// SIMD lane reorder: permute network
// Builds the 128-bit result from the two sources for one action code.
// ----------------------------------------------------------------------------
module slru_permute (
  input  logic [slru_pkg::ActionW-1:0] action,
  input  slru_pkg::vec_t               rs,
  input  slru_pkg::vec_t               rt,
  output slru_pkg::vec_t               rd
);
  import slru_pkg::*;

  // lane routing per action; byte = 8, halfword = 16, word = 32 bits
  always_comb begin
    rd = '0;
    case (action)
      ACT_COPY_HW: begin
        for (int i = 0; i < 4; i++) begin
          rd[16*i +: 16]     = rt[15:0];
          rd[16*(4+i) +: 16] = rt[79:64];
        end
      end
      ACT_COPY_LO_DW: rd = {rs[63:0], rt[63:0]};
      ACT_COPY_UP_DW: rd = {rt[127:64], rs[127:64]};
      ACT_EXCH_CTR_HW: begin
        rd = rt;
        rd[31:16] = rt[47:32];
        rd[47:32] = rt[31:16];
        rd[95:80] = rt[111:96];
        rd[111:96] = rt[95:80];
      end
      ACT_EXCH_CTR_W: rd = {rt[127:96], rt[63:32], rt[95:64], rt[31:0]};
      ACT_EXCH_EVEN_HW: begin
        rd = rt;
        rd[15:0]   = rt[47:32];
        rd[47:32]  = rt[15:0];
        rd[79:64]  = rt[111:96];
        rd[111:96] = rt[79:64];
      end
      ACT_EXCH_EVEN_W: rd = {rt[127:96], rt[31:0], rt[63:32], rt[95:64]};
      ACT_EXT_LO_B: begin
        for (int i = 0; i < 8; i++) begin
          rd[8*(2*i) +: 8]   = rt[8*i +: 8];
          rd[8*(2*i+1) +: 8] = rs[8*i +: 8];
        end
      end
      ACT_EXT_LO_HW: begin
        for (int i = 0; i < 4; i++) begin
          rd[16*(2*i) +: 16]   = rt[16*i +: 16];
          rd[16*(2*i+1) +: 16] = rs[16*i +: 16];
        end
      end
      ACT_EXT_LO_W: rd = {rs[63:32], rt[63:32], rs[31:0], rt[31:0]};
      ACT_EXT_UP_B: begin
        for (int i = 0; i < 8; i++) begin
          rd[8*(2*i) +: 8]   = rt[8*(8+i) +: 8];
          rd[8*(2*i+1) +: 8] = rs[8*(8+i) +: 8];
        end
      end
      ACT_EXT_UP_HW: begin
        for (int i = 0; i < 4; i++) begin
          rd[16*(2*i) +: 16]   = rt[16*(4+i) +: 16];
          rd[16*(2*i+1) +: 16] = rs[16*(4+i) +: 16];
        end
      end
      ACT_EXT_UP_W: rd = {rs[127:96], rt[127:96], rs[95:64], rt[95:64]};
      ACT_INTLV_EVEN_HW: begin
        for (int i = 0; i < 4; i++) begin
          rd[16*(2*i) +: 16]   = rt[16*(2*i) +: 16];
          rd[16*(2*i+1) +: 16] = rs[16*(2*i) +: 16];
        end
      end
      ACT_INTLV_HW: begin
        for (int i = 0; i < 4; i++) begin
          rd[16*(2*i) +: 16]   = rt[16*i +: 16];
          rd[16*(2*i+1) +: 16] = rs[16*(4+i) +: 16];
        end
      end
      ACT_PACK_B: begin
        for (int i = 0; i < 8; i++) begin
          rd[8*i +: 8]     = rt[8*(2*i) +: 8];
          rd[8*(8+i) +: 8] = rs[8*(2*i) +: 8];
        end
      end
      ACT_PACK_HW: begin
        for (int i = 0; i < 4; i++) begin
          rd[16*i +: 16]     = rt[16*(2*i) +: 16];
          rd[16*(4+i) +: 16] = rs[16*(2*i) +: 16];
        end
      end
      ACT_PACK_W: rd = {rs[95:64], rs[31:0], rt[95:64], rt[31:0]};
      ACT_REV_HW: begin
        for (int i = 0; i < 4; i++) begin
          rd[16*i +: 16]     = rt[16*(3-i) +: 16];
          rd[16*(4+i) +: 16] = rt[16*(7-i) +: 16];
        end
      end
      ACT_ROT3_W: rd = {rt[127:96], rt[31:0], rt[95:64], rt[63:32]};
      // undefined codes select no lane
      default: rd = '0;
    endcase
  end

endmodule

[src/simd_lane_reorder_unit.sv]
// ----------------------------------------------------------------------------
// SIMD lane reorder unit
// Copies, exchanges, extends, interleaves, packs, reverses or rotates lanes of two
// 128-bit sources into one 128-bit result, one word per cycle.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+-------------------
//   input    | in_action, in_rs_low/high, in_rt_low/hi| start && !busy
//   result   | out_rd_low, out_rd_high                | out_strobe
//
// A word passes the input register, the permute network and the result register.
// A new word is taken every cycle; busy stays low, the network is fully
// pipelined behind the input register.
// Synchronous active-low reset clears the valid bits; data registers hold.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module simd_lane_reorder_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [slru_pkg::ActionW-1:0] in_action,
  input  logic [slru_pkg::HalfW-1:0]   in_rs_low,
  input  logic [slru_pkg::HalfW-1:0]   in_rs_high,
  input  logic [slru_pkg::HalfW-1:0]   in_rt_low,
  input  logic [slru_pkg::HalfW-1:0]   in_rt_high,
  output logic                         out_strobe,
  output logic [slru_pkg::HalfW-1:0]   out_rd_low,
  output logic [slru_pkg::HalfW-1:0]   out_rd_high
);
  import slru_pkg::*;

  logic               in_vld_r;
  logic [ActionW-1:0] action_r;
  vec_t               rs_r;
  vec_t               rt_r;
  vec_t               rd_nxt;
  logic               out_vld_r;
  vec_t               rd_r;

  // never holds off a word
  assign busy = 1'b0;

  // input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      action_r <= in_action;
      rs_r     <= {in_rs_high, in_rs_low};
      rt_r     <= {in_rt_high, in_rt_low};
    end
  end

  slru_permute u_permute (
    .action (action_r),
    .rs     (rs_r),
    .rt     (rt_r),
    .rd     (rd_nxt)
  );

  // result stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      rd_r <= rd_nxt;
    end
  end

  assign out_strobe  = out_vld_r;
  assign out_rd_low  = rd_r[HalfW-1:0];
  assign out_rd_high = rd_r[VecW-1:HalfW];

endmodule

[src/slru_checker.sv]
// ----------------------------------------------------------------------------
// SIMD lane reorder unit: port checker
// Watches the top-level ports for latency and a few lane routing rules.
// ----------------------------------------------------------------------------
`include "simd_lane_reorder_unit_defines.svh"

module slru_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [slru_pkg::ActionW-1:0] in_action,
  input logic [slru_pkg::HalfW-1:0]   in_rs_low,
  input logic [slru_pkg::HalfW-1:0]   in_rt_low,
  input logic [slru_pkg::HalfW-1:0]   in_rt_high,
  input logic                         out_strobe,
  input logic [slru_pkg::HalfW-1:0]   out_rd_low,
  input logic [slru_pkg::HalfW-1:0]   out_rd_high
);
  import slru_pkg::*;

  // every accepted word yields a strobe after the input and result registers
  `SLRU_ASSERT_NEXT(a_latency, start && !busy, ##1 out_strobe, "accepted word produced no result")

  // no strobe without a matching word accepted earlier
  `SLRU_ASSERT_IMPL(a_no_spurious, out_strobe, $past(start && !busy, 2), "result without an accepted word")

  // undefined action codes give an all-zero result
  `SLRU_ASSERT_IMPL(a_undef_zero, out_strobe && ($past(in_action, 2) >= ActionCount), (out_rd_low == '0) && (out_rd_high == '0), "undefined action gave nonzero result")

  // copy lower doubleword: low half from rt, high half from rs
  `SLRU_ASSERT_IMPL(a_copy_lo, out_strobe && ($past(in_action, 2) == ACT_COPY_LO_DW), (out_rd_low == $past(in_rt_low, 2)) && (out_rd_high == $past(in_rs_low, 2)), "copy lower doubleword misrouted")

  // exchange even word keeps word 3 of rt in place
  `SLRU_ASSERT_IMPL(a_exch_w3, out_strobe && ($past(in_action, 2) == ACT_EXCH_EVEN_W), out_rd_high[63:32] == $past(in_rt_high[63:32], 2), "exchange even word moved word 3")

endmodule

bind simd_lane_reorder_unit slru_checker u_slru_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_action   (in_action),
  .in_rs_low   (in_rs_low),
  .in_rt_low   (in_rt_low),
  .in_rt_high  (in_rt_high),
  .out_strobe  (out_strobe),
  .out_rd_low  (out_rd_low),
  .out_rd_high (out_rd_high)
);
